### sv/fpts_pkg.sv
`timescale 1ns / 1ps

package fpts_pkg;

   localparam int NUM_FANS_DEF = 2;

   localparam int TEMP_W = 13;
   localparam int CURR_W = 12;
   localparam int CNT_W  = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 13;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [1:0] {
      OP_SENSE     = 2'd0,
      OP_PWM       = 2'd1,
      OP_SUPERVISE = 2'd2,
      OP_NONE      = 2'd3
   } opcode_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PWM_PERIOD    = 3'd0,
      CSR_ON_DUTY       = 3'd1,
      CSR_COUNT_TIMEOUT = 3'd2,
      CSR_RESTART_TICKS = 3'd3,
      CSR_FAN_ON_TEMP   = 3'd4,
      CSR_FAN_OFF_TEMP  = 3'd5,
      CSR_MIN_CURRENT   = 3'd6,
      CSR_HOT_TEMP      = 3'd7
   } csr_index_type;

   localparam logic [CNT_W-1:0]         PWM_PERIOD_RST    = 8'd10;
   localparam logic [CNT_W-1:0]         ON_DUTY_RST       = 8'd10;
   localparam logic [CNT_W-1:0]         COUNT_TIMEOUT_RST = 8'd100;
   localparam logic [CNT_W-1:0]         RESTART_TICKS_RST = 8'd15;
   localparam logic signed [TEMP_W-1:0] FAN_ON_TEMP_RST   = 13'sd496;
   localparam logic signed [TEMP_W-1:0] FAN_OFF_TEMP_RST  = 13'sd160;
   localparam logic signed [CURR_W-1:0] MIN_CURRENT_RST   = 12'sd0;
   localparam logic signed [TEMP_W-1:0] HOT_TEMP_RST      = 13'sd1120;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

endpackage

### sv/fan_pwm_tach_supervisor_unit.sv
`timescale 1ns / 1ps

// channel  direction  handshake            payload
// req      in         req_tvalid/tready    tuser opcode, tdata sensor sample
// rsp      out        rsp_tvalid/tready    tdata fan status
// csr      in         csr_wen              csr_addr, csr_wdata
//
// one request per clock while the output register is free or rsp_tready is high;
// a request is registered in the input register, then its state update and
// status land in the output register, which drives rsp_tvalid
// the input register takes one request while a finished status waits for rsp_tready
// reset is synchronous; config returns to defaults, tach counts to the timeout
// default

module fan_pwm_tach_supervisor_unit #(
   parameter int NumFans = fpts_pkg::NUM_FANS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // opcode [1:0]
   input  logic [1:0]                             req_tuser,
   // tach_one [0], tach_two [1], heatsink_temp [14:2], temp_sensor_fault [15],
   // output_current [27:16], zero [31:28]
   input  logic [fpts_pkg::REQ_DATA_W-1:0]        req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // fan_drive [0], fan_duty [8:1], fan_commanded [9], fan_in_shutdown [10],
   // fault_event [11], zero [15:12]
   output logic [fpts_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  logic                                   csr_wen,
   input  logic [fpts_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [fpts_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int CW = fpts_pkg::CNT_W;
   localparam int TW = fpts_pkg::TEMP_W;
   localparam int IW = fpts_pkg::CURR_W;
   localparam int RSP_DATA_W_L = fpts_pkg::RSP_DATA_W;

   // configuration
   logic [CW-1:0]        period_ff, on_duty_ff, timeout_ff, restart_ticks_ff;
   logic signed [TW-1:0] on_temp_ff, off_temp_ff, hot_temp_ff;
   logic signed [IW-1:0] min_curr_ff;

   // input stage
   logic                   in_valid_ff;
   fpts_pkg::opcode_type   in_op_ff;
   logic [1:0]             in_tach_ff;
   logic signed [TW-1:0]   in_temp_ff;
   logic                   in_fault_ff;
   logic signed [IW-1:0]   in_curr_ff;

   // fan state
   logic [CW-1:0] pwm_count_ff, pwm_count_in;
   logic [CW-1:0] duty_ff, duty_in;
   logic [CW-1:0] tach_count_ff [NumFans];
   logic [CW-1:0] tach_count_in [NumFans];
   logic [NumFans-1:0] prev_low_ff, prev_low_in;
   logic driven_ff, driven_in;
   logic shutdown_ff, shutdown_in;
   logic [CW-1:0] restart_ff, restart_in;
   logic use_off_ff, use_off_in;
   logic pin_ff, pin_in;
   logic event_in;

   // output stage
   logic                  out_valid_ff;
   logic [RSP_DATA_W_L-1:0] out_data_ff, out_data_in;

   logic advance;
   logic stalled;
   logic [CW-1:0] last;
   logic [CW-1:0] restart_inc;
   logic signed [TW-1:0] thresh;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff        <= fpts_pkg::PWM_PERIOD_RST;
         on_duty_ff       <= fpts_pkg::ON_DUTY_RST;
         timeout_ff       <= fpts_pkg::COUNT_TIMEOUT_RST;
         restart_ticks_ff <= fpts_pkg::RESTART_TICKS_RST;
         on_temp_ff       <= fpts_pkg::FAN_ON_TEMP_RST;
         off_temp_ff      <= fpts_pkg::FAN_OFF_TEMP_RST;
         min_curr_ff      <= fpts_pkg::MIN_CURRENT_RST;
         hot_temp_ff      <= fpts_pkg::HOT_TEMP_RST;
      end else if (csr_wen) begin
         case (csr_addr)
            fpts_pkg::CSR_PWM_PERIOD:    period_ff        <= csr_wdata[CW-1:0];
            fpts_pkg::CSR_ON_DUTY:       on_duty_ff       <= csr_wdata[CW-1:0];
            fpts_pkg::CSR_COUNT_TIMEOUT: timeout_ff       <= csr_wdata[CW-1:0];
            fpts_pkg::CSR_RESTART_TICKS: restart_ticks_ff <= csr_wdata[CW-1:0];
            fpts_pkg::CSR_FAN_ON_TEMP:   on_temp_ff       <= csr_wdata[TW-1:0];
            fpts_pkg::CSR_FAN_OFF_TEMP:  off_temp_ff      <= csr_wdata[TW-1:0];
            fpts_pkg::CSR_MIN_CURRENT:   min_curr_ff      <= csr_wdata[IW-1:0];
            fpts_pkg::CSR_HOT_TEMP:      hot_temp_ff      <= csr_wdata[TW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff    <= fpts_pkg::opcode_type'(req_tuser);
         in_tach_ff  <= req_tdata[1:0];
         in_temp_ff  <= req_tdata[14:2];
         in_fault_ff <= req_tdata[15];
         in_curr_ff  <= req_tdata[27:16];
      end
   end

   always_comb begin
      pwm_count_in = pwm_count_ff;
      duty_in      = duty_ff;
      prev_low_in  = prev_low_ff;
      driven_in    = driven_ff;
      shutdown_in  = shutdown_ff;
      restart_in   = restart_ff;
      use_off_in   = use_off_ff;
      pin_in       = pin_ff;
      event_in     = 1'b0;
      stalled      = 1'b0;
      last         = period_ff - 1'b1;
      restart_inc  = (restart_ff < fpts_pkg::CNT_MAX) ? restart_ff + 1'b1 : restart_ff;
      thresh       = use_off_ff ? off_temp_ff : on_temp_ff;
      for (int i = 0; i < NumFans; i++) begin
         tach_count_in[i] = tach_count_ff[i];
         if (tach_count_ff[i] < timeout_ff) begin
            stalled = 1'b1;
         end
      end
      case (in_op_ff)
         fpts_pkg::OP_SENSE: begin
            for (int i = 0; i < NumFans; i++) begin
               if (in_tach_ff[i]) begin
                  if (prev_low_ff[i] && tach_count_ff[i] < timeout_ff) begin
                     tach_count_in[i] = tach_count_ff[i] + 1'b1;
                  end
                  prev_low_in[i] = 1'b0;
               end else begin
                  prev_low_in[i] = 1'b1;
               end
            end
         end
         fpts_pkg::OP_PWM: begin
            pwm_count_in = (pwm_count_ff >= last) ? '0 : pwm_count_ff + 1'b1;
            pin_in       = pwm_count_in < duty_ff;
         end
         fpts_pkg::OP_SUPERVISE: begin
            for (int i = 0; i < NumFans; i++) begin
               tach_count_in[i] = '0;
            end
            if (driven_ff && stalled) begin
               shutdown_in = 1'b1;
               event_in    = 1'b1;
               duty_in     = '0;
               driven_in   = 1'b0;
               restart_in  = '0;
            end else if (shutdown_ff) begin
               restart_in = restart_inc;
               if (restart_inc >= restart_ticks_ff) begin
                  shutdown_in = 1'b0;
               end
            end else if (in_temp_ff > thresh || in_fault_ff) begin
               if (in_curr_ff >= min_curr_ff || in_temp_ff > hot_temp_ff) begin
                  use_off_in = 1'b1;
                  duty_in    = (on_duty_ff <= period_ff) ? on_duty_ff : period_ff;
                  driven_in  = 1'b1;
               end else begin
                  duty_in   = '0;
                  driven_in = 1'b0;
               end
            end else begin
               use_off_in = 1'b0;
               duty_in    = '0;
               driven_in  = 1'b0;
            end
         end
         default: ;
      endcase
      out_data_in = {4'b0000, event_in, shutdown_in, driven_in, duty_in, pin_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_count_ff <= '0;
         duty_ff      <= '0;
         prev_low_ff  <= '1;
         driven_ff    <= 1'b0;
         shutdown_ff  <= 1'b0;
         restart_ff   <= '0;
         use_off_ff   <= 1'b0;
         pin_ff       <= 1'b0;
         for (int i = 0; i < NumFans; i++) begin
            tach_count_ff[i] <= fpts_pkg::COUNT_TIMEOUT_RST;
         end
      end else if (advance) begin
         pwm_count_ff <= pwm_count_in;
         duty_ff      <= duty_in;
         prev_low_ff  <= prev_low_in;
         driven_ff    <= driven_in;
         shutdown_ff  <= shutdown_in;
         restart_ff   <= restart_in;
         use_off_ff   <= use_off_in;
         pin_ff       <= pin_in;
         for (int i = 0; i < NumFans; i++) begin
            tach_count_ff[i] <= tach_count_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   // a fault report always leaves the fan uncommanded, in shutdown, at zero duty
   a_event_shutdown: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff[11] |->
         !out_data_ff[9] && out_data_ff[10] && out_data_ff[8:1] == '0)
      else $error("fault event without shutdown");

   // the fan is never driven while waiting out a fault
   a_driven_excl: assert property (@(posedge clock) disable iff (reset)
      driven_ff |-> !shutdown_ff)
      else $error("fan driven during shutdown");

   // a nonzero duty only exists while the fan is commanded
   a_duty_driven: assert property (@(posedge clock) disable iff (reset)
      duty_ff != '0 |-> driven_ff)
      else $error("duty set while fan not driven");

endmodule
